@@ sv/rat_pkg.sv @@
package rat_pkg;

    // Table size and the widths that follow from it.
    localparam int ALARM_SLOTS = 16;
    localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(ALARM_SLOTS + 1);

    // Fixed field widths.
    localparam int REQ_W    = 3;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SLOTF_W  = 4;
    localparam int MASK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = HOUR_W + MIN_W + SEC_W;
    localparam int ENTRY_W  = TIME_W + 1;

    localparam int HOURS_PER_DAY = 24;
    localparam int MINS_PER_HOUR = 60;
    localparam int SECS_PER_MIN  = 60;

    // Request codes on the input channel.
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

    // Status codes on the result channel.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Internal command codes, after classification.
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REJECT = 3'd5;

    // Command queue between the front and the back.
    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [SLOTF_W-1:0] slot;
        logic               already_fired;
    } in_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   cur_hour;
        logic [MIN_W-1:0]    cur_minute;
        logic [SEC_W-1:0]    cur_second;
        logic [MASK_W-1:0]   fired_mask;
        logic [SLOTF_W-1:0]  slot_used;
        logic [STATUS_W-1:0] status;
    } out_t;

    typedef struct packed {
        logic [CMD_W-1:0]    op;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
        logic [SLOT_W-1:0]   slot;
        logic                fired;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    function automatic logic [TIME_W-1:0] pack_time(
        input logic [HOUR_W-1:0] h,
        input logic [MIN_W-1:0]  m,
        input logic [SEC_W-1:0]  s
    );
        return {h, m, s};
    endfunction

endpackage

@@ sv/rat_ram.sv @@
module rat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

@@ sv/rat_front.sv @@
module rat_front (
    input  logic         s_valid,
    output logic         s_ready,
    input  rat_pkg::in_t s_data,
    output logic         push_valid,
    input  logic         push_ready,
    output rat_pkg::cmd_t push_cmd
);

    logic range_ok;
    logic slot_ok;

    // Every time field must name a real time of day.
    assign range_ok = (s_data.hour < rat_pkg::HOUR_W'(rat_pkg::HOURS_PER_DAY))
                   && (s_data.minute < rat_pkg::MIN_W'(rat_pkg::MINS_PER_HOUR))
                   && (s_data.second < rat_pkg::SEC_W'(rat_pkg::SECS_PER_MIN));
    assign slot_ok  = int'(s_data.slot) < rat_pkg::ALARM_SLOTS;

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

    always_comb begin
        push_cmd.hour   = s_data.hour;
        push_cmd.minute = s_data.minute;
        push_cmd.second = s_data.second;
        push_cmd.slot   = rat_pkg::SLOT_W'(s_data.slot);
        push_cmd.fired  = s_data.already_fired;
        push_cmd.status = rat_pkg::ST_OK;
        push_cmd.op     = rat_pkg::CMD_REJECT;
        unique case (s_data.req_type)
            rat_pkg::REQ_TICK: begin
                push_cmd.op = rat_pkg::CMD_TICK;
            end
            rat_pkg::REQ_SET: begin
                if (range_ok) begin
                    push_cmd.op = rat_pkg::CMD_SET;
                end else begin
                    push_cmd.status = rat_pkg::ST_RANGE;
                end
            end
            rat_pkg::REQ_ADD: begin
                if (range_ok) begin
                    push_cmd.op = rat_pkg::CMD_ADD;
                end else begin
                    push_cmd.status = rat_pkg::ST_RANGE;
                end
            end
            rat_pkg::REQ_DEL: begin
                if (slot_ok) begin
                    push_cmd.op = rat_pkg::CMD_DEL;
                end else begin
                    push_cmd.status = rat_pkg::ST_EMPTY;
                end
            end
            rat_pkg::REQ_CLEAR: begin
                push_cmd.op = rat_pkg::CMD_CLEAR;
            end
            default: begin
                push_cmd.status = rat_pkg::ST_RANGE;
            end
        endcase
    end

endmodule

@@ sv/rat_cmd_queue.sv @@
module rat_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rat_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output rat_pkg::cmd_t out_cmd
);

    rat_pkg::cmd_t entry_reg [rat_pkg::CMDQ_DEPTH];
    logic [rat_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rat_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rat_pkg::QCNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign in_ready  = count_reg != rat_pkg::QCNT_W'(rat_pkg::CMDQ_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            if (wr_ptr_reg == rat_pkg::QPTR_W'(rat_pkg::CMDQ_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == rat_pkg::QPTR_W'(rat_pkg::CMDQ_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ sv/rat_back.sv @@
module rat_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rat_pkg::cmd_t cmd,
    output logic          m_valid,
    input  logic          m_ready,
    output rat_pkg::out_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [rat_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           pend_reg, pend_next;
    logic [rat_pkg::SLOT_W-1:0]     pidx_reg, pidx_next;
    logic [rat_pkg::ALARM_SLOTS-1:0] valid_reg, valid_next;
    logic [rat_pkg::HOUR_W-1:0]     hour_reg, hour_next;
    logic [rat_pkg::MIN_W-1:0]      minute_reg, minute_next;
    logic [rat_pkg::SEC_W-1:0]      second_reg, second_next;
    logic [rat_pkg::MASK_W-1:0]     mask_reg, mask_next;
    rat_pkg::cmd_t                  cmd_reg, cmd_next;
    rat_pkg::out_t                  res_reg, res_next;
    logic                           m_valid_reg, m_valid_next;

    logic [rat_pkg::HOUR_W-1:0]  tick_hour;
    logic [rat_pkg::MIN_W-1:0]   tick_minute;
    logic [rat_pkg::SEC_W-1:0]   tick_second;
    logic [rat_pkg::TIME_W-1:0]  now;
    logic [rat_pkg::SLOT_W-1:0]  cnt_idx;
    logic                        out_free;
    logic                        walk_end;

    logic                         wr_en;
    logic [rat_pkg::SLOT_W-1:0]   wr_addr;
    logic [rat_pkg::ENTRY_W-1:0]  wr_data;
    logic [rat_pkg::ENTRY_W-1:0]  rd_data;

    // Entry layout: done mark on top of the packed alarm time.
    rat_ram #(
        .WIDTH (rat_pkg::ENTRY_W),
        .DEPTH (rat_pkg::ALARM_SLOTS),
        .AW    (rat_pkg::SLOT_W)
    ) u_alarm_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cnt_idx),
        .rd_data (rd_data)
    );

    assign cnt_idx  = cnt_reg[rat_pkg::SLOT_W-1:0];
    assign walk_end = cnt_reg == rat_pkg::CNT_W'(rat_pkg::ALARM_SLOTS);
    assign out_free = !m_valid_reg || m_ready;
    assign now      = rat_pkg::pack_time(hour_reg, minute_reg, second_reg);
    assign m_valid  = m_valid_reg;
    assign m_data   = res_reg;

    // One second on, with carries into minutes and hours.
    always_comb begin
        tick_hour   = hour_reg;
        tick_minute = minute_reg;
        tick_second = second_reg + 1'b1;
        if (second_reg == rat_pkg::SEC_W'(rat_pkg::SECS_PER_MIN - 1)) begin
            tick_second = '0;
            tick_minute = minute_reg + 1'b1;
            if (minute_reg == rat_pkg::MIN_W'(rat_pkg::MINS_PER_HOUR - 1)) begin
                tick_minute = '0;
                tick_hour   = hour_reg + 1'b1;
                if (hour_reg == rat_pkg::HOUR_W'(rat_pkg::HOURS_PER_DAY - 1)) begin
                    tick_hour = '0;
                end
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        valid_next   = valid_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        mask_next    = mask_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        cmd_ready    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pidx_reg;
        wr_data      = {1'b1, rd_data[rat_pkg::TIME_W-1:0]};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready           = 1'b1;
                    cmd_next            = cmd;
                    res_next.fired_mask = '0;
                    res_next.slot_used  = '0;
                    res_next.status     = rat_pkg::ST_OK;
                    m_valid_next        = 1'b1;
                    unique case (cmd.op)
                        rat_pkg::CMD_TICK: begin
                            hour_next    = tick_hour;
                            minute_next  = tick_minute;
                            second_next  = tick_second;
                            cnt_next     = '0;
                            pend_next    = 1'b0;
                            mask_next    = '0;
                            m_valid_next = 1'b0;
                            state_next   = ST_TICK;
                        end
                        rat_pkg::CMD_SET: begin
                            hour_next   = cmd.hour;
                            minute_next = cmd.minute;
                            second_next = cmd.second;
                        end
                        rat_pkg::CMD_ADD: begin
                            cnt_next     = '0;
                            m_valid_next = 1'b0;
                            state_next   = ST_ADD;
                        end
                        rat_pkg::CMD_DEL: begin
                            if (valid_reg[cmd.slot]) begin
                                valid_next[cmd.slot] = 1'b0;
                            end else begin
                                res_next.status = rat_pkg::ST_EMPTY;
                            end
                        end
                        rat_pkg::CMD_CLEAR: begin
                            valid_next = '0;
                        end
                        default: begin
                            res_next.status = cmd.status;
                        end
                    endcase
                    res_next.cur_hour   = hour_next;
                    res_next.cur_minute = minute_next;
                    res_next.cur_second = second_next;
                end
            end
            ST_TICK: begin
                // The entry read in the previous cycle is checked against the new time.
                if (pend_reg && valid_reg[pidx_reg] && !rd_data[rat_pkg::TIME_W]
                        && rd_data[rat_pkg::TIME_W-1:0] == now) begin
                    wr_en = 1'b1;
                    if (int'(pidx_reg) < rat_pkg::MASK_W) begin
                        mask_next[4'(pidx_reg)] = 1'b1;
                    end
                end
                if (walk_end) begin
                    pend_next           = 1'b0;
                    state_next          = ST_IDLE;
                    m_valid_next        = 1'b1;
                    res_next.cur_hour   = hour_reg;
                    res_next.cur_minute = minute_reg;
                    res_next.cur_second = second_reg;
                    res_next.fired_mask = mask_next;
                    res_next.slot_used  = '0;
                    res_next.status     = rat_pkg::ST_OK;
                end else begin
                    pend_next = 1'b1;
                    pidx_next = cnt_idx;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            ST_ADD: begin
                res_next.cur_hour   = hour_reg;
                res_next.cur_minute = minute_reg;
                res_next.cur_second = second_reg;
                res_next.fired_mask = '0;
                res_next.slot_used  = '0;
                if (walk_end) begin
                    res_next.status = rat_pkg::ST_FULL;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end else if (!valid_reg[cnt_idx]) begin
                    wr_en               = 1'b1;
                    wr_addr             = cnt_idx;
                    wr_data             = {cmd_reg.fired,
                                           rat_pkg::pack_time(cmd_reg.hour, cmd_reg.minute,
                                                              cmd_reg.second)};
                    valid_next[cnt_idx] = 1'b1;
                    res_next.slot_used  = rat_pkg::SLOTF_W'(cnt_idx);
                    res_next.status     = rat_pkg::ST_OK;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            valid_reg   <= '0;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            valid_reg   <= valid_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= pidx_next;
        mask_reg <= mask_next;
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
    end

    // A walk only starts once the result register is free, so it stays empty throughout.
    a_walk_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending while a table walk is in progress");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= rat_pkg::CNT_W'(rat_pkg::ALARM_SLOTS))
        else $error("slot counter ran past the table");

    a_tick_first_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK && !pend_reg) |-> cnt_reg == '0)
        else $error("tick walk lost a pending read");

    a_full_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.status == rat_pkg::ST_FULL) |-> (&valid_reg))
        else $error("table reported full with a free slot");

endmodule

@@ sv/rtc_alarm_table.sv @@
// Channel   Ports                     Payload           Role
// request   s_valid/s_ready/s_data    rat_pkg::in_t     one request item in
// result    m_valid/m_ready/m_data    rat_pkg::out_t    one result item out
//
// Set time, delete, clear and rejected requests finish in the back end without a walk.
// On a tick the back end walks every slot through the alarm memory's single read
// port, one slot a cycle, and compares each live entry with the new time.
// An add walks the valid bits from slot zero up to the first free slot.
// Reset (aresetn low at a clock edge) sets the clock to 00:00:00 and empties the table.
// A two-item command queue lets requests be taken while the back end is busy or a
// result item is waiting for m_ready.
module rtc_alarm_table (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rat_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rat_pkg::out_t m_data
);

    // Classified request on its way into the queue.
    logic          push_valid;
    logic          push_ready;
    rat_pkg::cmd_t push_cmd;

    // Head of the queue, offered to the back end.
    logic          pop_valid;
    logic          pop_ready;
    rat_pkg::cmd_t pop_cmd;

    // The front end checks ranges and turns each request item into a command.
    // Range failures and bad slot indices become reject commands that carry
    // their status, so the back end never needs to look at raw fields again.
    rat_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // The queue decouples acceptance from execution.
    rat_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_cmd   (pop_cmd)
    );

    // The back end owns the clock, the valid bits and the alarm memory, and
    // holds the result register that drives the result channel.
    rat_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

@@ tb/rtc_alarm_table_tb.sv @@
module rtc_alarm_table_tb;

    // Testbench for the time-of-day clock with its table of one-shot alarms.
    // A sender process issues request items in bursts with random gaps, while a
    // receiver accepts result items under a stall pattern of its own. Every
    // accepted request is run through a local model of the clock and the table,
    // and the result item it should produce is queued. Each result item that
    // leaves the block is compared, field by field, with the oldest entry.

    // The run stops here if the block hangs. A correct run takes far fewer.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_ITEMS  = 1950;
    localparam int TAIL_CYCLES  = 40;

    // Request codes that the block must reject.
    localparam logic [rat_pkg::REQ_W-1:0] REQ_BAD_FIRST = 3'd5;
    localparam logic [rat_pkg::REQ_W-1:0] REQ_BAD_LAST  = 3'd7;

    // Seconds in one day, used to step a time forward by a few seconds.
    localparam int SECS_PER_DAY = rat_pkg::HOURS_PER_DAY * rat_pkg::MINS_PER_HOUR
                                * rat_pkg::SECS_PER_MIN;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_SELDOM,
        READY_LONG_STALLS
    } ready_mode_t;

    typedef enum int {
        SCN_ALARM_RUN,
        SCN_FILL_TABLE,
        SCN_DELETES,
        SCN_CLEAR,
        SCN_NOISE,
        SCN_TICK_RUN,
        SCN_SET_TIME
    } scenario_t;

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    rat_pkg::in_t    s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    rat_pkg::out_t   m_data;

    rtc_alarm_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Local copy of the clock and the alarm table.
    logic [rat_pkg::HOUR_W-1:0]  clk_hour;
    logic [rat_pkg::MIN_W-1:0]   clk_minute;
    logic [rat_pkg::SEC_W-1:0]   clk_second;
    logic                        alarm_on    [rat_pkg::ALARM_SLOTS];
    logic [rat_pkg::TIME_W-1:0]  alarm_at    [rat_pkg::ALARM_SLOTS];
    logic                        alarm_spent [rat_pkg::ALARM_SLOTS];

    // Result items still owed by the block, oldest first.
    rat_pkg::out_t awaited_reports[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Sender pacing: burst length left, and whether gaps are in use at all.
    int  burst_left = 0;
    bit  gaps_on    = 1'b1;

    // Receiver pacing.
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left  = 0;
    int          hold_left  = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Guard against a hang: the fail message and the end of the run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Applies one request to the local model and returns the result item
    // that the block ought to give for it.
    function automatic rat_pkg::out_t apply_request(input rat_pkg::in_t req);
        rat_pkg::out_t rep;
        bit            found;
        rep = '0;
        case (req.req_type)
            rat_pkg::REQ_TICK: begin
                // Move on one second, carrying into minutes and hours.
                if (int'(clk_second) + 1 >= rat_pkg::SECS_PER_MIN) begin
                    clk_second = '0;
                    if (int'(clk_minute) + 1 >= rat_pkg::MINS_PER_HOUR) begin
                        clk_minute = '0;
                        if (int'(clk_hour) + 1 >= rat_pkg::HOURS_PER_DAY)
                            clk_hour = '0;
                        else
                            clk_hour = clk_hour + 1'b1;
                    end else begin
                        clk_minute = clk_minute + 1'b1;
                    end
                end else begin
                    clk_second = clk_second + 1'b1;
                end
                // Every live alarm that has not gone off and matches the new
                // time fires now, and is marked so that it never fires again.
                for (int k = 0; k < rat_pkg::ALARM_SLOTS; k++) begin
                    if (alarm_on[k] && !alarm_spent[k] &&
                        alarm_at[k] == {clk_hour, clk_minute, clk_second}) begin
                        alarm_spent[k] = 1'b1;
                        if (k < rat_pkg::MASK_W)
                            rep.fired_mask[k] = 1'b1;
                    end
                end
            end
            rat_pkg::REQ_SET: begin
                if (req.hour >= rat_pkg::HOURS_PER_DAY ||
                    req.minute >= rat_pkg::MINS_PER_HOUR ||
                    req.second >= rat_pkg::SECS_PER_MIN) begin
                    rep.status = rat_pkg::ST_RANGE;
                end else begin
                    clk_hour   = req.hour;
                    clk_minute = req.minute;
                    clk_second = req.second;
                end
            end
            rat_pkg::REQ_ADD: begin
                // The range check wins over the full-table check.
                if (req.hour >= rat_pkg::HOURS_PER_DAY ||
                    req.minute >= rat_pkg::MINS_PER_HOUR ||
                    req.second >= rat_pkg::SECS_PER_MIN) begin
                    rep.status = rat_pkg::ST_RANGE;
                end else begin
                    found = 1'b0;
                    for (int k = 0; k < rat_pkg::ALARM_SLOTS; k++) begin
                        if (!found && !alarm_on[k]) begin
                            found          = 1'b1;
                            alarm_on[k]    = 1'b1;
                            alarm_at[k]    = {req.hour, req.minute, req.second};
                            alarm_spent[k] = req.already_fired;
                            rep.slot_used  = k[rat_pkg::SLOTF_W-1:0];
                        end
                    end
                    rep.status = found ? rat_pkg::ST_OK : rat_pkg::ST_FULL;
                end
            end
            rat_pkg::REQ_DEL: begin
                if (int'(req.slot) >= rat_pkg::ALARM_SLOTS)
                    rep.status = rat_pkg::ST_EMPTY;
                else if (!alarm_on[req.slot])
                    rep.status = rat_pkg::ST_EMPTY;
                else
                    alarm_on[req.slot] = 1'b0;
            end
            rat_pkg::REQ_CLEAR: begin
                for (int k = 0; k < rat_pkg::ALARM_SLOTS; k++)
                    alarm_on[k] = 1'b0;
            end
            default: begin
                rep.status = rat_pkg::ST_RANGE;
            end
        endcase
        rep.cur_hour   = clk_hour;
        rep.cur_minute = clk_minute;
        rep.cur_second = clk_second;
        return rep;
    endfunction

    // A request with every field random; callers then fill in what matters.
    function automatic rat_pkg::in_t random_request(input logic [rat_pkg::REQ_W-1:0] kind);
        rat_pkg::in_t req;
        req.req_type      = kind;
        req.hour          = rat_pkg::HOUR_W'($urandom_range(0, 31));
        req.minute        = rat_pkg::MIN_W'($urandom_range(0, 63));
        req.second        = rat_pkg::SEC_W'($urandom_range(0, 63));
        req.slot          = rat_pkg::SLOTF_W'($urandom_range(0, 15));
        req.already_fired = 1'($urandom_range(0, 1));
        return req;
    endfunction

    // Returns the time n seconds after h:m:s, wrapping at midnight.
    function automatic logic [rat_pkg::TIME_W-1:0] time_after(input int h, input int m,
                                                              input int s, input int n);
        int total;
        total = (h * 3600 + m * 60 + s + n) % SECS_PER_DAY;
        return {5'(total / 3600), 6'((total / 60) % 60), 6'(total % 60)};
    endfunction

    // Hands one item to the block. Between bursts the valid line drops for a
    // random number of cycles; within a burst it stays high from one item to
    // the next, so back-to-back transfers are exercised as well.
    task automatic send_item(input rat_pkg::in_t req);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            @(negedge aclk);
            s_valid = 1'b0;
            s_data  = random_request(3'($urandom_range(0, 7)));
            repeat (gap - 1) @(negedge aclk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        awaited_reports.push_back(apply_request(req));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(random_request(rat_pkg::REQ_TICK));
    endtask

    task automatic send_set(input int h, input int m, input int s);
        rat_pkg::in_t req;
        req        = random_request(rat_pkg::REQ_SET);
        req.hour   = rat_pkg::HOUR_W'(h);
        req.minute = rat_pkg::MIN_W'(m);
        req.second = rat_pkg::SEC_W'(s);
        send_item(req);
    endtask

    task automatic send_add(input int h, input int m, input int s, input bit done);
        rat_pkg::in_t req;
        req               = random_request(rat_pkg::REQ_ADD);
        req.hour          = rat_pkg::HOUR_W'(h);
        req.minute        = rat_pkg::MIN_W'(m);
        req.second        = rat_pkg::SEC_W'(s);
        req.already_fired = done;
        send_item(req);
    endtask

    task automatic send_delete(input int slot);
        rat_pkg::in_t req;
        req      = random_request(rat_pkg::REQ_DEL);
        req.slot = rat_pkg::SLOTF_W'(slot);
        send_item(req);
    endtask

    task automatic send_clear();
        send_item(random_request(rat_pkg::REQ_CLEAR));
    endtask

    // Holds the sender back, valid low, until every owed result has arrived.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Receiver: the ready line follows a pattern that changes mode at random, from
    // always ready through to long stalls.
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (ready_mode)
            READY_ALWAYS: m_ready = 1'b1;
            READY_MOSTLY: m_ready = ($urandom_range(0, 9) < 7);
            READY_SELDOM: m_ready = ($urandom_range(0, 3) == 0);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    m_ready = 1'b0;
                end else begin
                    m_ready = 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        hold_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Result checker: each accepted result item is matched to the oldest
    // prediction. The values read here are those the block saw at this edge.
    always @(posedge aclk) begin
        rat_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_reports.size() == 0) begin
                report_mismatch("unexpected result item", 64'(m_data), 64'(0));
            end else begin
                want = awaited_reports.pop_front();
                if (m_data.cur_hour !== want.cur_hour)
                    report_mismatch("cur_hour", 64'(m_data.cur_hour),
                                    64'(want.cur_hour));
                if (m_data.cur_minute !== want.cur_minute)
                    report_mismatch("cur_minute", 64'(m_data.cur_minute),
                                    64'(want.cur_minute));
                if (m_data.cur_second !== want.cur_second)
                    report_mismatch("cur_second", 64'(m_data.cur_second),
                                    64'(want.cur_second));
                if (m_data.fired_mask !== want.fired_mask)
                    report_mismatch("fired_mask", 64'(m_data.fired_mask),
                                    64'(want.fired_mask));
                if (m_data.slot_used !== want.slot_used)
                    report_mismatch("slot_used", 64'(m_data.slot_used),
                                    64'(want.slot_used));
                if (m_data.status !== want.status)
                    report_mismatch("status", 64'(m_data.status), 64'(want.status));
            end
        end
    end

    // The clock counts from reset, wraps at midnight, and refuses bad times.
    task automatic test_clock_wrap();
        send_tick();
        send_set(23, 59, 59);
        send_tick();
        send_set(12, 59, 59);
        send_tick();
        send_set(31, 63, 63);
        send_set(24, 0, 0);
        send_set(0, 60, 0);
        send_set(0, 0, 60);
        send_set(0, 0, 0);
    endtask

    // Alarms fire once, an alarm added as already done never fires, deletes
    // of empty slots are refused, freed slots are reused lowest first, and
    // codes outside the set of requests are rejected.
    task automatic test_alarm_basics();
        send_set(5, 10, 20);
        send_add(5, 10, 21, 1'b0);
        send_add(5, 10, 21, 1'b1);
        send_add(5, 10, 22, 1'b0);
        send_add(24, 0, 0, 1'b0);
        send_tick();
        send_tick();
        send_set(5, 10, 20);
        send_tick();
        send_delete(1);
        send_delete(1);
        send_delete(15);
        send_add(23, 59, 59, 1'b0);
        send_clear();
        for (int code = REQ_BAD_FIRST; code <= REQ_BAD_LAST; code++)
            send_item(random_request(3'(code)));
    endtask

    // A burst of well-formed alarm activity: set the clock, add alarms a few
    // seconds ahead (some sharing a time, some already done), tick, not always past
    // them, and clear or delete. Sometimes the base time sits just before midnight.
    task automatic alarm_run();
        int h, m, s, count, ticks, offset;
        logic [rat_pkg::TIME_W-1:0] at;
        if ($urandom_range(0, 3) == 0) begin
            h = 23;
            m = 59;
            s = $urandom_range(50, 59);
        end else begin
            h = $urandom_range(0, 23);
            m = $urandom_range(0, 59);
            s = $urandom_range(0, 59);
        end
        send_set(h, m, s);
        count  = $urandom_range(1, 4);
        offset = $urandom_range(1, 8);
        repeat (count) begin
            if ($urandom_range(0, 2) != 0)
                offset = $urandom_range(1, 8);
            at = time_after(h, m, s, offset);
            send_add(int'(at[16:12]), int'(at[11:6]), int'(at[5:0]),
                     $urandom_range(0, 4) == 0);
        end
        ticks = $urandom_range(1, 10);
        repeat (ticks) send_tick();
        if ($urandom_range(0, 2) == 0)
            send_clear();
        else
            repeat ($urandom_range(0, 3)) send_delete($urandom_range(0, 15));
    endtask

    task automatic run_scenario(input scenario_t which);
        rat_pkg::in_t req;
        case (which)
            SCN_ALARM_RUN: alarm_run();
            SCN_FILL_TABLE: begin
                // Enough adds to fill an empty table, often more; half the time an
                // out-of-range add follows; it must report the range fault.
                repeat ($urandom_range(rat_pkg::ALARM_SLOTS, rat_pkg::ALARM_SLOTS + 3))
                    send_add($urandom_range(0, 23), $urandom_range(0, 59),
                             $urandom_range(0, 59), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) == 0)
                    send_add($urandom_range(24, 31), $urandom_range(0, 63),
                             $urandom_range(0, 63), 1'($urandom_range(0, 1)));
            end
            SCN_DELETES: repeat ($urandom_range(2, 6)) send_delete($urandom_range(0, 15));
            SCN_CLEAR: send_clear();
            SCN_NOISE: begin
                repeat ($urandom_range(3, 10)) begin
                    req = random_request(3'($urandom_range(0, 7)));
                    send_item(req);
                end
            end
            SCN_TICK_RUN: repeat ($urandom_range(5, 30)) send_tick();
            default: begin
                req = random_request(rat_pkg::REQ_SET);
                if ($urandom_range(0, 1) == 0) begin
                    req.hour   = rat_pkg::HOUR_W'($urandom_range(0, 23));
                    req.minute = rat_pkg::MIN_W'($urandom_range(0, 59));
                    req.second = rat_pkg::SEC_W'($urandom_range(0, 59));
                end
                send_item(req);
            end
        endcase
    endtask

    // The bulk of the run. Alarm runs are picked most often, since they aim to make
    // alarms fire; the rest mixes table churn, long tick runs, sets and noise.
    task automatic test_random_traffic();
        int        rounds;
        int        pick;
        scenario_t which;
        rounds = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (rounds % 25 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (rounds % 60 == 30)
                wait_for_drain();
            pick = $urandom_range(0, 11);
            if (pick < 5)
                which = SCN_ALARM_RUN;
            else
                which = scenario_t'((pick - 4 > int'(SCN_SET_TIME)) ?
                                    int'(SCN_SET_TIME) : pick - 4);
            run_scenario(which);
            rounds++;
        end
    endtask

    initial begin
        for (int k = 0; k < rat_pkg::ALARM_SLOTS; k++) begin
            alarm_on[k]    = 1'b0;
            alarm_at[k]    = '0;
            alarm_spent[k] = 1'b0;
        end
        clk_hour   = '0;
        clk_minute = '0;
        clk_second = '0;

        // Synchronous reset, held low before the tests start.
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_clock_wrap();
        test_alarm_basics();
        wait_for_drain();
        test_random_traffic();

        // All stimulus is in: drop valid, collect what is owed, then let the
        // block run on a little in case it sends anything extra.
        @(negedge aclk);
        s_valid = 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && awaited_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ rtc_alarm_table.f @@
sv/rat_pkg.sv
sv/rat_ram.sv
sv/rat_front.sv
sv/rat_cmd_queue.sv
sv/rat_back.sv
sv/rtc_alarm_table.sv
tb/rtc_alarm_table_tb.sv
